FILE: sv/counting_bloom_filter_macros.svh
// Assertion helpers shared by the filter RTL.
// Each macro expects clk_i and rst_ni in scope.
`ifndef COUNTING_BLOOM_FILTER_MACROS_SVH
`define COUNTING_BLOOM_FILTER_MACROS_SVH

// Same-cycle implication.
`define CBF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/cbf_pkg.sv
`default_nettype none

package cbf_pkg;

  localparam int unsigned MaxCounters = 65536;
  localparam int unsigned MaxProbes   = 32;
  localparam int unsigned MinSlots    = 16;

  localparam int ModeW    = 2;
  localparam int ByteW    = 8;
  localparam int SlotsW   = 17;
  localparam int ProbesW  = 6;
  localparam int TotalW   = 32;
  localparam int CtrW     = 4;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 32;

  localparam logic [SlotsW-1:0]  SlotsRst  = 17'd65536;
  localparam logic [ProbesW-1:0] ProbesRst = 6'd7;

  localparam logic [CfgIdxW-1:0] CfgIdxSlots  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxProbes = 8'd1;

  localparam logic [CtrW-1:0] CtrMax = 4'd15;

  localparam logic [63:0] SipKey0    = 64'h736f6d6570736575;
  localparam logic [63:0] SipKey1    = 64'h646f72616e646f6d;
  localparam logic [63:0] SipV2Init  = SipKey0 ^ 64'h6c7967656e657261;
  localparam logic [63:0] SipV3Init  = SipKey1 ^ 64'h7465646279746573;
  localparam logic [63:0] SipFinXor  = 64'h00000000000000ff;
  localparam logic [63:0] FnvBasis   = 64'hcbf29ce484222325;

  typedef enum logic [1:0] {
    ModeAdd    = 2'd0,
    ModeTest   = 2'd1,
    ModeRemove = 2'd2,
    ModeClear  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    HsIdle,
    HsBlk,
    HsTailSetup,
    HsTail,
    HsFin,
    HsOut
  } hash_state_e;

  typedef enum logic [2:0] {
    CsClear,
    CsIdle,
    CsHash,
    CsDiv,
    CsRead,
    CsWrite,
    CsOut
  } ctrl_state_e;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } sip_t;

  typedef struct packed {
    logic             start;
    logic             byte_valid;
    logic             last;
    logic [ByteW-1:0] key_byte;
  } hash_req_t;

  typedef struct packed {
    logic        idle;
    logic        done;
    logic [63:0] h1;
    logic [63:0] h2;
  } hash_rsp_t;

  // FNV-1a step; the prime is 2^40 + 0x1b3, so multiply by shifts and adds.
  function automatic logic [63:0] fnv_step(logic [63:0] s, logic [ByteW-1:0] b);
    logic [63:0] x;
    x = s ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

  // First half of a SipRound: two independent adds.
  function automatic sip_t sip_half0(sip_t v);
    sip_t r;
    r.a = v.a + v.b;
    r.b = {v.b[50:0], v.b[63:51]} ^ r.a;
    r.a = {r.a[31:0], r.a[63:32]};
    r.c = v.c + v.d;
    r.d = {v.d[47:0], v.d[63:48]} ^ r.c;
    return r;
  endfunction

  // Second half of a SipRound.
  function automatic sip_t sip_half1(sip_t v);
    sip_t r;
    r.a = v.a + v.d;
    r.d = {v.d[42:0], v.d[63:43]} ^ r.a;
    r.c = v.c + v.b;
    r.b = {v.b[46:0], v.b[63:47]} ^ r.c;
    r.c = {r.c[31:0], r.c[63:32]};
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/cbf_if.sv
`default_nettype none

interface cbf_in_if import cbf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ModeW-1:0] mode;
  logic [ByteW-1:0] key_byte;
  logic             byte_valid;
  logic             last;
  modport source(output valid, mode, key_byte, byte_valid, last, input ready);
  modport sink(input valid, mode, key_byte, byte_valid, last, output ready);
endinterface

interface cbf_out_if import cbf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              found;
  logic [ModeW-1:0]  done_mode;
  logic [TotalW-1:0] element_count;
  modport source(output valid, found, done_mode, element_count, input ready);
  modport sink(input valid, found, done_mode, element_count, output ready);
endinterface

interface cbf_cfg_if import cbf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: sv/counting_bloom_filter.sv
// Channel   Dir   Payload                                  Transfer when
// in_i      in    mode, key_byte, byte_valid, last         valid & ready
// out_o     out   found, done_mode, element_count          valid & ready
// cfg_i     in    index, data (0 counter_slots, 1 hash_count) valid & ready
//
// Sequence: a key byte that completes an 8-byte block runs one SipRound in two
//   halves, and no byte is taken meanwhile. The last item adds the hash finish,
//   then per probe a remainder unit (2 bits a cycle) and a read-modify-write
//   on the one counter memory. Remove of a present key runs the probes twice.
// Reset: a clearing pass zeroes all MAX_COUNTERS counters; no item is taken
//   until it ends. Clear mode repeats the same pass.
// Stalls: the result sits in an output register; new items are taken while it
//   waits, and the block only holds at the next result.
`default_nettype none
`include "counting_bloom_filter_macros.svh"

module counting_bloom_filter import cbf_pkg::*; #(
  parameter int unsigned MAX_COUNTERS = MaxCounters,
  parameter int unsigned MAX_PROBES   = MaxProbes
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cbf_in_if.sink    in_i,
  cbf_out_if.source out_o,
  cbf_cfg_if.sink   cfg_i
);

  localparam int AW = $clog2(MAX_COUNTERS);
  localparam int MW = $clog2(MAX_COUNTERS + 1);

  ctrl_state_e        state_q, state_d;
  logic [SlotsW-1:0]  slots_q;
  logic [ProbesW-1:0] probes_q;
  mode_e              mode_q, mode_d;
  logic               pass_q, pass_d;
  logic               present_q, present_d;
  logic [ProbesW-1:0] probe_q, probe_d;
  logic [63:0]        pos_q, pos_d;
  logic [AW-1:0]      addr_q, addr_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic               clr_res_q, clr_res_d;
  logic [TotalW-1:0]  total_q, total_d;
  logic               res_found_q, res_found_d;
  logic               out_vld_q;
  logic               out_found_q;
  mode_e              out_mode_q;
  logic [TotalW-1:0]  out_cnt_q;
  logic               out_load;

  hash_req_t          hreq;
  hash_rsp_t          hrsp;

  logic               div_start;
  logic [63:0]        div_num;
  logic               div_done;
  logic [MW-1:0]      div_rem;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [CtrW-1:0]    mem_wdata;
  logic               mem_re;
  logic [CtrW-1:0]    mem_rdata;

  logic [31:0]        slots32;
  logic [31:0]        m32;
  logic [MW-1:0]      m;
  logic [ProbesW-1:0] k;
  logic               last_probe;
  logic               in_xfer;
  logic               nz;
  logic               pres_n;

  // Config: always ready, unknown indexes drop.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q  <= SlotsRst;
      probes_q <= ProbesRst;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CfgIdxSlots) begin
        slots_q <= cfg_i.data[SlotsW-1:0];
      end else if (cfg_i.index == CfgIdxProbes) begin
        probes_q <= cfg_i.data[ProbesW-1:0];
      end
    end
  end

  // Clamp slot and probe counts to the supported range.
  assign slots32 = 32'(slots_q);
  always_comb begin
    if (slots32 < 32'(MinSlots)) begin
      m32 = 32'(MinSlots);
    end else if (slots32 > 32'(MAX_COUNTERS)) begin
      m32 = 32'(MAX_COUNTERS);
    end else begin
      m32 = slots32;
    end
    if (probes_q == '0) begin
      k = ProbesW'(1);
    end else if (probes_q > ProbesW'(MAX_PROBES)) begin
      k = ProbesW'(MAX_PROBES);
    end else begin
      k = probes_q;
    end
  end
  assign m          = m32[MW-1:0];
  assign last_probe = (probe_q == k - ProbesW'(1));

  // Input side: bytes stream into the hash unit whenever both are idle.
  assign in_i.ready      = (state_q == CsIdle) && hrsp.idle;
  assign in_xfer         = in_i.valid && in_i.ready;
  assign hreq.start      = in_xfer;
  assign hreq.byte_valid = in_i.byte_valid;
  assign hreq.last       = in_i.last;
  assign hreq.key_byte   = in_i.key_byte;

  cbf_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hreq),
    .rsp_o  (hrsp)
  );

  cbf_mod #(
    .MAX_COUNTERS (MAX_COUNTERS)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (m),
    .done_o  (div_done),
    .rem_o   (div_rem)
  );

  cbf_store #(
    .DEPTH (MAX_COUNTERS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (addr_d),
    .rdata_o (mem_rdata)
  );

  assign nz     = (mem_rdata != '0);
  assign pres_n = present_q && nz;

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    pass_d      = pass_q;
    present_d   = present_q;
    probe_d     = probe_q;
    pos_d       = pos_q;
    addr_d      = addr_q;
    clr_d       = clr_q;
    clr_res_d   = clr_res_q;
    total_d     = total_q;
    res_found_d = res_found_q;
    div_start   = 1'b0;
    div_num     = pos_q + hrsp.h2;
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = mem_rdata;
    mem_re      = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      CsClear: begin
        // Sweep the store one counter a cycle.
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(MAX_COUNTERS - 1)) begin
          clr_d   = '0;
          state_d = clr_res_q ? CsOut : CsIdle;
        end
      end
      CsIdle: begin
        if (in_xfer && in_i.last) begin
          mode_d  = mode_e'(in_i.mode);
          state_d = CsHash;
        end
      end
      CsHash: begin
        if (hrsp.done) begin
          pos_d     = hrsp.h1;
          probe_d   = '0;
          present_d = 1'b1;
          pass_d    = 1'b0;
          if (mode_q == ModeClear) begin
            clr_d       = '0;
            clr_res_d   = 1'b1;
            total_d     = '0;
            res_found_d = 1'b0;
            state_d     = CsClear;
          end else begin
            div_start = 1'b1;
            div_num   = hrsp.h1;
            state_d   = CsDiv;
          end
        end
      end
      CsDiv: begin
        if (div_done) begin
          addr_d  = div_rem[AW-1:0];
          mem_re  = 1'b1;
          state_d = CsRead;
        end
      end
      CsRead: begin
        state_d = CsWrite;
      end
      CsWrite: begin
        present_d = pres_n;
        if (mode_q == ModeAdd) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata + CtrW'(mem_rdata != CtrMax);
        end else if (mode_q == ModeRemove && pass_q) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata - CtrW'(nz);
        end
        if (!last_probe) begin
          // Advance to the next probe; the sum wraps at 64 bits.
          probe_d   = probe_q + ProbesW'(1);
          pos_d     = pos_q + hrsp.h2;
          div_start = 1'b1;
          state_d   = CsDiv;
        end else if (mode_q == ModeRemove && !pass_q && pres_n) begin
          // Key present: rerun the probes and decrement.
          pass_d    = 1'b1;
          probe_d   = '0;
          pos_d     = hrsp.h1;
          div_start = 1'b1;
          div_num   = hrsp.h1;
          state_d   = CsDiv;
        end else begin
          case (mode_q)
            ModeAdd: begin
              res_found_d = pres_n;
              if (!pres_n && total_q != '1) begin
                total_d = total_q + TotalW'(1);
              end
            end
            ModeTest: begin
              res_found_d = pres_n;
            end
            ModeRemove: begin
              res_found_d = pass_q;
              if (pass_q && total_q != '0) begin
                total_d = total_q - TotalW'(1);
              end
            end
            default: res_found_d = 1'b0;
          endcase
          clr_res_d = 1'b0;
          state_d   = CsOut;
        end
      end
      CsOut: begin
        // Hold until the output register is free.
        if (!out_vld_q || out_o.ready) begin
          out_load  = 1'b1;
          clr_res_d = 1'b0;
          state_d   = CsIdle;
        end
      end
      default: state_d = CsIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= CsClear;
      clr_q     <= '0;
      clr_res_q <= 1'b0;
      total_q   <= '0;
      out_vld_q <= 1'b0;
      mode_q    <= ModeAdd;
      pass_q    <= 1'b0;
      present_q <= 1'b0;
      probe_q   <= '0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      clr_res_q <= clr_res_d;
      total_q   <= total_d;
      mode_q    <= mode_d;
      pass_q    <= pass_d;
      present_q <= present_d;
      probe_q   <= probe_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    addr_q      <= addr_d;
    res_found_q <= res_found_d;
    if (out_load) begin
      out_found_q <= res_found_q;
      out_mode_q  <= mode_q;
      out_cnt_q   <= total_q;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.found         = out_found_q;
  assign out_o.done_mode     = out_mode_q;
  assign out_o.element_count = out_cnt_q;

  `CBF_ASSERT_IMPL(a_we_phase, mem_we, (state_q == CsClear) || (state_q == CsWrite), "store write outside sweep or write-back")
  `CBF_ASSERT_IMPL(a_in_idle, in_xfer, (state_q == CsIdle) && hrsp.idle, "item transfer while busy")
  `CBF_ASSERT_NEXT(a_div_read, div_done && (state_q == CsDiv), state_q == CsRead, "read not issued after remainder")
  `CBF_ASSERT_IMPL(a_out_free, out_load, !out_vld_q || out_o.ready, "pending result overwritten")

endmodule

`default_nettype wire

FILE: sv/cbf_hash.sv
`default_nettype none

module cbf_hash import cbf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  hash_req_t req_i,
  output hash_rsp_t rsp_o
);

  hash_state_e state_q, state_d;
  sip_t        v_q, v_d;
  logic [63:0] buf_q, buf_d;
  logic [63:0] fnv_q, fnv_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [2:0]  half_q, half_d;
  logic        fin_q, fin_d;
  logic        done_q, done_d;
  logic [63:0] h1_q, h1_d;
  logic [63:0] h2_q, h2_d;
  logic [2:0]  lane;
  logic [63:0] blk;
  logic [63:0] tail;

  assign lane = cnt_q[2:0];
  assign blk  = buf_q | ({56'd0, req_i.key_byte} << {lane, 3'b000});
  assign tail = {cnt_q, buf_q[55:0]};

  always_comb begin
    state_d = state_q;
    v_d     = v_q;
    buf_d   = buf_q;
    fnv_d   = fnv_q;
    cnt_d   = cnt_q;
    half_d  = half_q;
    fin_d   = fin_q;
    done_d  = 1'b0;
    h1_d    = h1_q;
    h2_d    = h2_q;
    case (state_q)
      HsIdle: begin
        if (req_i.start) begin
          if (req_i.byte_valid) begin
            fnv_d = fnv_step(fnv_q, req_i.key_byte);
            cnt_d = cnt_q + 8'd1;
            buf_d = blk;
            if (lane == 3'd7) begin
              v_d.d   = v_q.d ^ blk;
              half_d  = 3'd0;
              fin_d   = req_i.last;
              state_d = HsBlk;
            end else if (req_i.last) begin
              state_d = HsTailSetup;
            end
          end else if (req_i.last) begin
            state_d = HsTailSetup;
          end
        end
      end
      HsBlk: begin
        half_d = half_q + 3'd1;
        if (!half_q[0]) begin
          v_d = sip_half0(v_q);
        end else begin
          v_d     = sip_half1(v_q);
          v_d.a   = v_d.a ^ buf_q;
          buf_d   = '0;
          state_d = fin_q ? HsTailSetup : HsIdle;
        end
      end
      HsTailSetup: begin
        v_d.d   = v_q.d ^ tail;
        buf_d   = tail;
        half_d  = 3'd0;
        state_d = HsTail;
      end
      HsTail: begin
        half_d = half_q + 3'd1;
        if (!half_q[0]) begin
          v_d = sip_half0(v_q);
        end else begin
          v_d     = sip_half1(v_q);
          v_d.a   = v_d.a ^ buf_q;
          v_d.c   = v_d.c ^ SipFinXor;
          half_d  = 3'd0;
          state_d = HsFin;
        end
      end
      HsFin: begin
        half_d = half_q + 3'd1;
        if (!half_q[0]) begin
          v_d = sip_half0(v_q);
        end else begin
          v_d = sip_half1(v_q);
          if (half_q == 3'd5) begin
            state_d = HsOut;
          end
        end
      end
      HsOut: begin
        h1_d    = v_q.a ^ v_q.b ^ v_q.c ^ v_q.d;
        h2_d    = fnv_q | 64'd1;
        done_d  = 1'b1;
        v_d     = '{a: 64'd0, b: 64'd0, c: SipV2Init, d: SipV3Init};
        buf_d   = '0;
        fnv_d   = FnvBasis;
        cnt_d   = '0;
        fin_d   = 1'b0;
        state_d = HsIdle;
      end
      default: state_d = HsIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= HsIdle;
      v_q     <= '{a: 64'd0, b: 64'd0, c: SipV2Init, d: SipV3Init};
      buf_q   <= '0;
      fnv_q   <= FnvBasis;
      cnt_q   <= '0;
      half_q  <= '0;
      fin_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      v_q     <= v_d;
      buf_q   <= buf_d;
      fnv_q   <= fnv_d;
      cnt_q   <= cnt_d;
      half_q  <= half_d;
      fin_q   <= fin_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h1_q <= h1_d;
    h2_q <= h2_d;
  end

  assign rsp_o.idle = (state_q == HsIdle);
  assign rsp_o.done = done_q;
  assign rsp_o.h1   = h1_q;
  assign rsp_o.h2   = h2_q;

endmodule

`default_nettype wire

FILE: sv/cbf_mod.sv
`default_nettype none

// Remainder of a 64-bit numerator, two bits per cycle.
module cbf_mod import cbf_pkg::*; #(
  parameter int unsigned MAX_COUNTERS = MaxCounters
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [63:0]                          num_i,
  input  logic [$clog2(MAX_COUNTERS+1)-1:0]    den_i,
  output logic                                 done_o,
  output logic [$clog2(MAX_COUNTERS+1)-1:0]    rem_o
);

  localparam int MW = $clog2(MAX_COUNTERS + 1);

  logic          busy_q;
  logic          done_q;
  logic [4:0]    step_q;
  logic [63:0]   num_q;
  logic [MW-1:0] rem_q;
  logic [MW-1:0] den_q;
  logic [MW-1:0] rem1;
  logic [MW-1:0] rem2;

  function automatic logic [MW-1:0] rstep(logic [MW-1:0] r, logic b, logic [MW-1:0] d);
    logic [MW:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[MW-1:0];
  endfunction

  assign rem1 = rstep(rem_q, num_q[63], den_q);
  assign rem2 = rstep(rem1, num_q[62], den_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 5'd1;
        if (step_q == '1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      num_q <= num_q << 2;
      rem_q <= rem2;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

FILE: sv/cbf_store.sv
`default_nettype none

module cbf_store import cbf_pkg::*; #(
  parameter int unsigned DEPTH = MaxCounters
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [CtrW-1:0]          wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [CtrW-1:0]          rdata_o
);

  logic [CtrW-1:0] mem [DEPTH];
  logic [CtrW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: tb/counting_bloom_filter_tb.sv
`timescale 1ns / 1ps

module counting_bloom_filter_tb import cbf_pkg::*;;

  localparam logic [63:0] HashKeyLo = 64'h736f6d6570736575;
  localparam logic [63:0] HashKeyHi = 64'h646f72616e646f6d;
  localparam logic [63:0] FnvSeed   = 64'd14695981039346656037;
  localparam logic [63:0] FnvMul    = 64'd1099511628211;

  // One key-byte transfer, with an optional typed-in outcome for table rows.
  typedef struct {
    mode_e       mode;
    logic [7:0]  kb;
    bit          bv;
    bit          last;
    bit          typed;
    bit          t_found;
    logic [31:0] t_count;
  } key_item_t;

  typedef struct {
    bit          found;
    mode_e       mode;
    logic [31:0] count;
  } outcome_t;

  typedef struct {
    int         len;
    logic [7:0] b [0:15];
  } short_key_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #2 clk_i = ~clk_i;

  cbf_in_if  in_if ();
  cbf_out_if out_if ();
  cbf_cfg_if cfg_if ();

  counting_bloom_filter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // ---------------------------------------------------------------------------
  // Filter predictor: own copy of the hash state, counters and registers.
  // ---------------------------------------------------------------------------
  logic [63:0] sv0, sv1, sv2, sv3, sblock, fnv_acc;
  logic [7:0]  key_len;
  logic [31:0] stored_keys;
  logic [16:0] slots_reg = 17'd65536;
  logic [5:0]  probes_reg = 6'd7;
  logic [3:0]  bucket [0:65535];

  key_item_t  stim_q [$];
  outcome_t   outcome_q [$];
  short_key_t key_pool [$];
  int  mismatches = 0;
  int  items_queued = 0;
  bit  tx_busy = 1'b0;
  bit  hold_req = 1'b0;

  function automatic logic [63:0] rotl(logic [63:0] x, int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic void sip_mix(inout logic [63:0] a, b, c, d);
    a = a + b; b = rotl(b, 13); b = b ^ a; a = rotl(a, 32);
    c = c + d; d = rotl(d, 16); d = d ^ c;
    a = a + d; d = rotl(d, 21); d = d ^ a;
    c = c + b; b = rotl(b, 17); b = b ^ c; c = rotl(c, 32);
  endfunction

  task automatic restart_hash();
    sv0 = 64'd0;
    sv1 = 64'd0;
    sv2 = HashKeyLo ^ 64'h6c7967656e657261;
    sv3 = HashKeyHi ^ 64'h7465646279746573;
    sblock = 64'd0;
    fnv_acc = FnvSeed;
    key_len = 8'd0;
  endtask

  task automatic absorb_byte(logic [7:0] b);
    int lane;
    lane = key_len[2:0];
    sblock = sblock | ({56'd0, b} << (8 * lane));
    fnv_acc = (fnv_acc ^ {56'd0, b}) * FnvMul;
    key_len = key_len + 8'd1;
    if (lane == 7) begin
      sv3 = sv3 ^ sblock;
      sip_mix(sv0, sv1, sv2, sv3);
      sv0 = sv0 ^ sblock;
      sblock = 64'd0;
    end
  endtask

  function automatic logic [63:0] sip_digest();
    logic [63:0] a, b, c, d, tail;
    a = sv0; b = sv1; c = sv2; d = sv3;
    tail = {key_len, 56'd0} | sblock;
    d = d ^ tail;
    sip_mix(a, b, c, d);
    a = a ^ tail;
    c = c ^ 64'hff;
    sip_mix(a, b, c, d);
    sip_mix(a, b, c, d);
    sip_mix(a, b, c, d);
    return a ^ b ^ c ^ d;
  endfunction

  // Advance the predictor by one accepted transfer; report the outcome if any.
  task automatic filter_step(input key_item_t it, output bit has_out, output outcome_t o);
    logic [63:0] m, h1, h2, pos;
    int k;
    bit present;
    has_out = 1'b0;
    o = '{found: 1'b0, mode: it.mode, count: 32'd0};
    if (it.bv) absorb_byte(it.kb);
    if (!it.last) return;
    m = {47'd0, slots_reg};
    if (m < 16) m = 16;
    if (m > 65536) m = 65536;
    k = probes_reg;
    if (k < 1) k = 1;
    if (k > 32) k = 32;
    h1 = sip_digest();
    h2 = fnv_acc | 64'd1;
    restart_hash();
    present = 1'b1;
    if (it.mode == ModeClear) begin
      foreach (bucket[j]) bucket[j] = 4'd0;
      stored_keys = 32'd0;
    end else begin
      for (int i = 0; i < k; i++) begin
        pos = (h1 + 64'(i) * h2) % m;
        if (bucket[pos] == 4'd0) present = 1'b0;
        if (it.mode == ModeAdd && bucket[pos] != 4'd15) bucket[pos] = bucket[pos] + 4'd1;
      end
      if (it.mode == ModeAdd) begin
        o.found = present;
        if (!present && stored_keys != 32'hffff_ffff) stored_keys = stored_keys + 1;
      end else if (it.mode == ModeTest) begin
        o.found = present;
      end else if (present) begin
        for (int i = 0; i < k; i++) begin
          pos = (h1 + 64'(i) * h2) % m;
          if (bucket[pos] != 4'd0) bucket[pos] = bucket[pos] - 4'd1;
        end
        if (stored_keys != 32'd0) stored_keys = stored_keys - 1;
        o.found = 1'b1;
      end
    end
    o.count = stored_keys;
    has_out = 1'b1;
  endtask

  // Mostly short gaps, a few long ones, and calm runs with none at all.
  function automatic int pick_gap(ref int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm = $urandom_range(20, 120);
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Key-byte sender: present queued transfers, with random gaps between them.
  // ---------------------------------------------------------------------------
  initial begin
    key_item_t cur;
    bit        has_out;
    outcome_t  o;
    int        gap, calm;
    gap = 0;
    calm = 0;
    in_if.valid = 1'b0;
    in_if.mode = ModeAdd;
    in_if.key_byte = '0;
    in_if.byte_valid = 1'b0;
    in_if.last = 1'b0;
    forever begin
      @(posedge clk_i);
      if (in_if.valid && in_if.ready) begin
        filter_step(cur, has_out, o);
        if (has_out) begin
          if (cur.typed) o = '{found: cur.t_found, mode: cur.mode, count: cur.t_count};
          outcome_q.push_back(o);
        end
        tx_busy = 1'b0;
        gap = pick_gap(calm);
      end
      if (!tx_busy) begin
        if (gap > 0) gap--;
        else if (stim_q.size() > 0) begin
          cur = stim_q.pop_front();
          tx_busy = 1'b1;
        end
      end
      in_if.valid <= tx_busy;
      in_if.mode <= cur.mode;
      in_if.key_byte <= cur.kb;
      in_if.byte_valid <= cur.bv;
      in_if.last <= cur.last;
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: check each transfer against the oldest outcome.
  // ---------------------------------------------------------------------------
  initial begin
    outcome_t e;
    int stall, hold, calm;
    stall = 0;
    hold = 0;
    calm = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        if (outcome_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result with nothing expected: found=%0d mode=%0d count=%0d",
                                         out_if.found, out_if.done_mode, out_if.element_count);
        end else begin
          e = outcome_q.pop_front();
          if (out_if.found !== e.found || out_if.done_mode !== e.mode ||
              out_if.element_count !== e.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp found=%0d mode=%0d count=%0d, got found=%0d mode=%0d count=%0d",
                       e.found, e.mode, e.count, out_if.found, out_if.done_mode,
                       out_if.element_count);
          end
        end
        stall = pick_gap(calm);
      end
      // Long hold-off, counted here, so the block fills up and stalls its input.
      if (hold_req) begin
        hold = 800;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic queue_item(mode_e md, logic [7:0] kb, bit bv, bit last);
    stim_q.push_back('{mode: md, kb: kb, bv: bv, last: last, typed: 1'b0,
                       t_found: 1'b0, t_count: 32'd0});
    items_queued++;
  endtask

  function automatic mode_e any_mode();
    return mode_e'($urandom_range(0, 3));
  endfunction

  // Queue one whole key: bytes with random noise transfers among them, then the trigger.
  task automatic queue_key(mode_e md, int len, short_key_t sk);
    logic [7:0] b;
    bit split_end;
    split_end = (len == 0) || ($urandom_range(0, 9) < 3);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) queue_item(any_mode(), 8'($urandom), 1'b0, 1'b0);
      b = (len <= 16) ? sk.b[i] : 8'($urandom);
      if (i == len - 1 && !split_end) queue_item(md, b, 1'b1, 1'b1);
      else queue_item(any_mode(), b, 1'b1, 1'b0);
    end
    if (split_end) queue_item(md, 8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic queue_random(int n_items);
    short_key_t sk;
    int r, len, stop;
    mode_e md;
    stop = items_queued + n_items;
    while (items_queued < stop) begin
      r = $urandom_range(0, 99);
      md = (r < 45) ? ModeAdd : (r < 75) ? ModeTest : ModeRemove;
      if (key_pool.size() > 0 && $urandom_range(0, 9) < 6) begin
        sk = key_pool[$urandom_range(0, key_pool.size() - 1)];
        len = sk.len;
      end else begin
        // Rare long keys may wrap the 8-bit length.
        len = ($urandom_range(0, 99) < 3) ? $urandom_range(250, 300) : $urandom_range(0, 12);
        sk.len = len;
        foreach (sk.b[j]) sk.b[j] = 8'($urandom);
        if (len <= 16) begin
          if (key_pool.size() < 40) key_pool.push_back(sk);
          else key_pool[$urandom_range(0, 39)] = sk;
        end
      end
      queue_key(md, len, sk);
    end
  endtask

  // Hold until every transfer is out and every outcome has come back.
  task automatic drain();
    while (stim_q.size() > 0 || tx_busy || outcome_q.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    if (idx == CfgIdxSlots) slots_reg = data[16:0];
    else if (idx == CfgIdxProbes) probes_reg = data[5:0];
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_phase(logic [31:0] slots, logic [31:0] probes, bit clear_first, int n);
    short_key_t sk;
    write_reg(CfgIdxSlots, slots);
    write_reg(CfgIdxProbes, probes);
    sk.len = 3;
    foreach (sk.b[j]) sk.b[j] = 8'($urandom);
    if (clear_first) queue_key(ModeClear, 3, sk);
    queue_random(n);
    drain();
  endtask

  // Directed rows: mode, byte, byte_valid, last, typed, found, count.
  typedef struct {
    mode_e       mode;
    logic [7:0]  kb;
    bit          bv;
    bit          last;
    bit          typed;
    bit          found;
    logic [31:0] count;
  } dir_row_t;

  dir_row_t dir_tab [0:21];

  initial begin
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    restart_hash();
    stored_keys = 32'd0;
    foreach (bucket[j]) bucket[j] = 4'd0;
    dir_tab = '{
      // empty key: absent after reset, then add, test, add again, remove down to nothing
      '{ModeTest,   8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 32'd0},
      '{ModeAdd,    8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 32'd1},
      '{ModeTest,   8'hff, 1'b0, 1'b1, 1'b1, 1'b1, 32'd1},
      '{ModeAdd,    8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 32'd1},
      '{ModeRemove, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 32'd0},
      '{ModeRemove, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 32'd0},
      '{ModeRemove, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 32'd0},
      // nine-byte key crossing a block, with a noise transfer inside, then two one-byte keys
      '{ModeAdd,    8'hff, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ModeTest,   8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ModeRemove, 8'h55, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ModeClear,  8'haa, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ModeAdd,    8'h01, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ModeAdd,    8'h80, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ModeAdd,    8'h7f, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ModeAdd,    8'hfe, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ModeAdd,    8'h55, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ModeAdd,    8'h3c, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0},
      '{ModeTest,   8'h3c, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0},
      '{ModeRemove, 8'hc3, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0},
      // clear with key bytes: found 0, count 0, empty key gone
      '{ModeClear,  8'h12, 1'b1, 1'b1, 1'b1, 1'b0, 32'd0},
      '{ModeTest,   8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 32'd0},
      '{ModeAdd,    8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 32'd1}
    };
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i])
      stim_q.push_back('{mode: dir_tab[i].mode, kb: dir_tab[i].kb, bv: dir_tab[i].bv,
                         last: dir_tab[i].last, typed: dir_tab[i].typed,
                         t_found: dir_tab[i].found, t_count: dir_tab[i].count});
    drain();

    // Reset settings first, with one long receiver hold-off while keys keep coming.
    queue_random(500);
    hold_req = 1'b1;
    drain();
    // Smallest store, most probes: counters saturate; out-of-range values clamp.
    run_phase(32'd0, 32'd63, 1'b1, 150);
    run_phase(32'd17, 32'd0, 1'b0, 400);
    run_phase(32'hffff_ffff, 32'd32, 1'b0, 150);
    run_phase(32'd1000, 32'd3, 1'b1, 400);
    run_phase(32'd65536, 32'd7, 1'b0, 300);

    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("counting_bloom_filter_tb OK");
    end else begin
      $display("counting_bloom_filter_tb NOT OK");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #100ms;
    $display("counting_bloom_filter_tb NOT OK");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/cbf_pkg.sv
sv/cbf_if.sv
sv/cbf_hash.sv
sv/cbf_mod.sv
sv/cbf_store.sv
sv/counting_bloom_filter.sv
tb/counting_bloom_filter_tb.sv
